// File: src/int128_alu_macros.svh
// assertion macros for the int128 alu
`ifndef INT128_ALU_MACROS_SVH
`define INT128_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define IA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("int128_alu check failed");
`define IA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("int128_alu reset check failed");
`else
`define IA_ASSERT(lbl, prop)
`define IA_ASSERT_RST(lbl, prop)
`endif
`endif

// File: src/ia_pkg.sv
// shared types and constants of the int128 alu
package ia_pkg;

    localparam int WORD_BITS_DEF = 128;
    localparam int HALF_BITS     = 64;
    localparam int SHIFT_BITS    = 7;
    localparam int OPCODE_BITS   = 4;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_AND  = 4'd4,
        OP_OR   = 4'd5,
        OP_XOR  = 4'd6,
        OP_NOT  = 4'd7,
        OP_SHL  = 4'd8,
        OP_SAR  = 4'd9,
        OP_ROL1 = 4'd10,
        OP_ROR1 = 4'd11
    } ia_opcode_t;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_MUL,
        MODE_DIV
    } ia_mode_t;

    typedef struct packed {
        logic     valid;
        ia_mode_t mode;
        logic     neg;
        logic     dz;
    } ia_ctl_t;

endpackage

// File: src/ia_prep.sv
// operand decode: simple ops done here, multiply and divide set up for the cell chain
module ia_prep #(
    parameter int WORD_BITS = ia_pkg::WORD_BITS_DEF
) (
    input  logic                          valid_i,
    input  logic [ia_pkg::OPCODE_BITS-1:0] opcode_i,
    input  logic [WORD_BITS-1:0]          a_i,
    input  logic [WORD_BITS-1:0]          b_i,
    input  logic [ia_pkg::SHIFT_BITS-1:0] shift_i,
    output ia_pkg::ia_ctl_t               ctl_o,
    output logic [WORD_BITS-1:0]          acc_o,
    output logic [WORD_BITS-1:0]          x_o,
    output logic [WORD_BITS-1:0]          y_o
);

    logic sa;
    logic sb;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] mb;

    assign sa = a_i[WORD_BITS-1];
    assign sb = b_i[WORD_BITS-1];
    assign ma = sa ? ('0 - a_i) : a_i;
    assign mb = sb ? ('0 - b_i) : b_i;

    always_comb begin
        ctl_o.valid = valid_i;
        ctl_o.mode  = ia_pkg::MODE_PASS;
        ctl_o.neg   = 1'b0;
        ctl_o.dz    = 1'b0;
        acc_o       = '0;
        x_o         = '0;
        y_o         = '0;
        unique case (ia_pkg::ia_opcode_t'(opcode_i))
            ia_pkg::OP_ADD:  acc_o = a_i + b_i;
            ia_pkg::OP_SUB:  acc_o = a_i - b_i;
            ia_pkg::OP_MUL: begin
                ctl_o.mode = ia_pkg::MODE_MUL;
                x_o        = a_i;
                y_o        = b_i;
            end
            ia_pkg::OP_DIV: begin
                if (b_i == '0) begin
                    ctl_o.dz = 1'b1;
                end else begin
                    ctl_o.mode = ia_pkg::MODE_DIV;
                    ctl_o.neg  = sa ^ sb;
                    x_o        = ma;
                    y_o        = mb;
                end
            end
            ia_pkg::OP_AND:  acc_o = a_i & b_i;
            ia_pkg::OP_OR:   acc_o = a_i | b_i;
            ia_pkg::OP_XOR:  acc_o = a_i ^ b_i;
            ia_pkg::OP_NOT:  acc_o = ~a_i;
            ia_pkg::OP_SHL:  acc_o = a_i << shift_i;
            // vacated top bits fill with the sign; the shift count is at most 127
            ia_pkg::OP_SAR:  acc_o = WORD_BITS'($signed(a_i) >>> shift_i);
            ia_pkg::OP_ROL1: acc_o = {a_i[WORD_BITS-2:0], a_i[WORD_BITS-1]};
            ia_pkg::OP_ROR1: acc_o = {a_i[0], a_i[WORD_BITS-1:1]};
            default:         acc_o = '0;
        endcase
    end

endmodule

// File: src/ia_cell.sv
// one step cell: a shift-add bit of the multiply or a restoring bit of the divide; in pass mode it only registers
module ia_cell #(
    parameter int WORD_BITS = ia_pkg::WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  ia_pkg::ia_ctl_t      ctl_i,
    input  logic [WORD_BITS-1:0] acc_i,
    input  logic [WORD_BITS-1:0] x_i,
    input  logic [WORD_BITS-1:0] y_i,
    output ia_pkg::ia_ctl_t      ctl_o,
    output logic [WORD_BITS-1:0] acc_o,
    output logic [WORD_BITS-1:0] x_o,
    output logic [WORD_BITS-1:0] y_o
);

    ia_pkg::ia_ctl_t      ctl_reg;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [WORD_BITS-1:0] rem2;
    logic [WORD_BITS:0]   diff;
    logic                 ge;

    assign rem2 = {acc_i[WORD_BITS-2:0], x_i[WORD_BITS-1]};
    assign diff = {1'b0, rem2} - {1'b0, y_i};
    assign ge   = ~diff[WORD_BITS];

    always_comb begin
        acc_next = acc_i;
        x_next   = x_i;
        y_next   = y_i;
        unique case (ctl_i.mode)
            ia_pkg::MODE_MUL: begin
                acc_next = acc_i + (y_i[0] ? x_i : '0);
                x_next   = x_i << 1;
                y_next   = y_i >> 1;
            end
            ia_pkg::MODE_DIV: begin
                // quotient bits fill in from the bottom as the dividend leaves the top
                acc_next = ge ? diff[WORD_BITS-1:0] : rem2;
                x_next   = {x_i[WORD_BITS-2:0], ge};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign acc_o = acc_reg;
    assign x_o   = x_reg;
    assign y_o   = y_reg;

endmodule

// File: src/int128_alu.sv
// top level of the int128 alu: decode stage, chain of step cells, output register
//
//  channel  | dir | tdata                                          | tuser
//  s_       | in  | a_hi, a_lo, b_hi, b_lo, shift_amount           | opcode
//  m_       | out | result_hi, result_lo                           | divide_by_zero
//
// one word per cycle in and out while the output is not stalled; a word passes through
// the decode register, one cell per bit of the multiply or divide, and the output register
// every opcode runs through the same cell chain, so words leave in order
// reset clears the valid bits of every stage; payload is not reset
// a stalled output freezes the chain unless its last cell is empty
module int128_alu #(
    parameter int WORD_BITS = ia_pkg::WORD_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [263:0] s_tdata,  // a_hi, a_lo, b_hi, b_lo, shift_amount, zero pad
    input  logic [3:0]   s_tuser,  // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // result_hi, result_lo
    output logic [0:0]   m_tuser   // divide_by_zero
);

    localparam int HB = ia_pkg::HALF_BITS;

    logic [2*HB-1:0]      a_full;
    logic [2*HB-1:0]      b_full;
    logic [WORD_BITS-1:0] a_w;
    logic [WORD_BITS-1:0] b_w;

    ia_pkg::ia_ctl_t      ctl_s [0:WORD_BITS+1];
    logic [WORD_BITS-1:0] acc_s [0:WORD_BITS+1];
    logic [WORD_BITS-1:0] x_s   [0:WORD_BITS+1];
    logic [WORD_BITS-1:0] y_s   [0:WORD_BITS+1];

    logic                 en;
    logic                 out_ld;
    logic                 out_valid_reg;
    logic [2*HB-1:0]      out_data_reg, out_data_next;
    logic                 out_dz_reg;
    logic [WORD_BITS-1:0] res_w;
    logic [2*HB-1:0]      res_full;

    assign a_full = {s_tdata[0 +: HB], s_tdata[HB +: HB]};
    assign b_full = {s_tdata[2*HB +: HB], s_tdata[3*HB +: HB]};
    assign a_w    = a_full[WORD_BITS-1:0];
    assign b_w    = b_full[WORD_BITS-1:0];

    assign out_ld   = !out_valid_reg || m_tready;
    assign en       = out_ld || !ctl_s[WORD_BITS+1].valid;
    assign s_tready = en;

    ia_prep #(.WORD_BITS(WORD_BITS)) u_prep (
        .valid_i  (s_tvalid),
        .opcode_i (s_tuser),
        .a_i      (a_w),
        .b_i      (b_w),
        .shift_i  (s_tdata[4*HB +: ia_pkg::SHIFT_BITS]),
        .ctl_o    (ctl_s[0]),
        .acc_o    (acc_s[0]),
        .x_o      (x_s[0]),
        .y_o      (y_s[0])
    );

    // the decode register acts like a pass-mode cell and does no arithmetic on its own
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_s[1] <= '0;
        end else if (en) begin
            ctl_s[1] <= ctl_s[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_s[1] <= acc_s[0];
            x_s[1]   <= x_s[0];
            y_s[1]   <= y_s[0];
        end
    end

    for (genvar k = 1; k <= WORD_BITS; k++) begin : g_cell
        ia_cell #(.WORD_BITS(WORD_BITS)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (ctl_s[k]),
            .acc_i   (acc_s[k]),
            .x_i     (x_s[k]),
            .y_i     (y_s[k]),
            .ctl_o   (ctl_s[k+1]),
            .acc_o   (acc_s[k+1]),
            .x_o     (x_s[k+1]),
            .y_o     (y_s[k+1])
        );
    end

    always_comb begin
        if (ctl_s[WORD_BITS+1].mode == ia_pkg::MODE_DIV) begin
            res_w = ctl_s[WORD_BITS+1].neg ? ('0 - x_s[WORD_BITS+1]) : x_s[WORD_BITS+1];
        end else begin
            res_w = acc_s[WORD_BITS+1];
        end
        res_full      = (2*HB)'(res_w);
        out_data_next = {res_full[HB-1:0], res_full[2*HB-1:HB]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ld) begin
            out_valid_reg <= ctl_s[WORD_BITS+1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld && ctl_s[WORD_BITS+1].valid) begin
            out_data_reg <= out_data_next;
            out_dz_reg   <= ctl_s[WORD_BITS+1].dz;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_dz_reg;

`include "int128_alu_macros.svh"

    `IA_ASSERT(a_dz_zero, m_tvalid && m_tuser[0] |-> m_tdata == '0)
    `IA_ASSERT(a_full_stall, m_tvalid && !m_tready && ctl_s[WORD_BITS+1].valid |-> !s_tready)
    `IA_ASSERT(a_out_from_chain, !m_tvalid && !ctl_s[WORD_BITS+1].valid |=> !m_tvalid)
    `IA_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid && !ctl_s[1].valid)

endmodule
